/* hdl/tts_pkg.sv */
// Shared constants and types of the tag token scanner.
package tts_pkg;

  localparam int MAX_STRING  = 4096;
  localparam int POS_W       = 13;
  localparam int OFF_W       = 12;
  localparam int LEN_W       = 13;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TAG_SET_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_SET_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_SET_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_SET_3 = 8'd3;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_PERIOD = 8'h2E;

  localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_STRING);
  localparam logic [OFF_W-1:0] OFF_MAX   = OFF_W'(MAX_STRING - 1);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_STRING);
  localparam logic [LEN_W-1:0] LEN_EMIT  = LEN_W'(2);

  // Classification of one byte, as the scan logic needs it.
  typedef struct packed {
    logic letter;
    logic alnum;
    logic tag;
    logic zero;
    logic period;
    logic eos;
  } byte_class_t;

  // Handshake status of the queue toward its producer and consumer.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

/* hdl/tts_front.sv */
// Front end: tag set registers and byte classification.
module tts_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_string,
  input  tts_pkg::queue_status_t        q_status,
  output logic                          push,
  output tts_pkg::byte_class_t          push_data
);
  import tts_pkg::*;

  logic [CFG_DATA_W-1:0] tag_set [4];
  logic                  letter;
  logic                  digit;
  logic                  tag_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) tag_set[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAG_SET_0: tag_set[0] <= cfg_data;
        REG_TAG_SET_1: tag_set[1] <= cfg_data;
        REG_TAG_SET_2: tag_set[2] <= cfg_data;
        REG_TAG_SET_3: tag_set[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    letter  = data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    digit   = data_byte inside {[8'h30:8'h39]};
    tag_bit = tag_set[data_byte[7:6]][data_byte[5:0]];
    push_data.letter = letter;
    push_data.alnum  = letter | digit;
    // A zero byte is never a tag character.
    push_data.tag    = tag_bit && (data_byte != CHAR_NUL);
    push_data.zero   = (data_byte == CHAR_NUL);
    push_data.period = (data_byte == CHAR_PERIOD);
    push_data.eos    = end_of_string;
  end

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

endmodule

/* hdl/tts_queue.sv */
// Two-entry queue of classified bytes between front and back.
module tts_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tts_pkg::byte_class_t   push_data,
  input  logic                   pop,
  output tts_pkg::byte_class_t   head,
  output tts_pkg::queue_status_t status
);
  import tts_pkg::*;

  byte_class_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.valid = (count != '0);

endmodule

/* hdl/tts_back.sv */
// Back end: token scan state and the registered result.
module tts_back (
  input  logic                        clk,
  input  logic                        rst,
  input  tts_pkg::queue_status_t      q_status,
  input  tts_pkg::byte_class_t        head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tts_pkg::OFF_W-1:0]   token_offset,
  output logic [tts_pkg::LEN_W-1:0]   token_length,
  output logic                        capitalize
);
  import tts_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             in_token, in_token_next;
  logic [OFF_W-1:0] token_start, token_start_next;
  logic [LEN_W-1:0] token_count_len, token_count_len_next;
  logic             sentence_start, sentence_start_next;
  logic             token_cap, token_cap_next;
  logic             scan_stopped, scan_stopped_next;
  logic             emit;
  logic [OFF_W-1:0] emit_offset;
  logic [LEN_W-1:0] emit_length;
  logic             emit_cap;
  logic             extended;

  assign pop = q_status.valid && (!out_valid || out_ready);

  always_comb begin
    byte_position_next   = byte_position;
    in_token_next        = in_token;
    token_start_next     = token_start;
    token_count_len_next = token_count_len;
    sentence_start_next  = sentence_start;
    token_cap_next       = token_cap;
    scan_stopped_next    = scan_stopped;
    extended             = 1'b0;
    emit                 = 1'b0;
    emit_offset          = token_start;
    emit_length          = token_count_len;
    emit_cap             = token_cap;

    if (!scan_stopped) begin
      if (in_token) begin
        if (head.alnum) begin
          if (token_count_len < LEN_MAX) token_count_len_next = token_count_len + LEN_W'(1);
          extended = 1'b1;
        end else begin
          emit          = (token_count_len >= LEN_EMIT);
          in_token_next = 1'b0;
        end
      end
      if (!extended && head.tag) begin
        in_token_next        = 1'b1;
        token_start_next     = (byte_position < POS_W'(OFF_MAX)) ? byte_position[OFF_W-1:0]
                                                                 : OFF_MAX;
        token_count_len_next = LEN_W'(1);
        if (head.letter)      token_cap_next = 1'b0;
        else if (head.period) token_cap_next = 1'b1;
        else                  token_cap_next = sentence_start;
      end
      if (head.zero) scan_stopped_next = 1'b1;
      if (head.letter)      sentence_start_next = 1'b0;
      else if (head.period) sentence_start_next = 1'b1;
    end

    if (head.eos) begin
      // The open token, if long enough, closes with the string.
      if (!emit && in_token_next && (token_count_len_next >= LEN_EMIT)) begin
        emit        = 1'b1;
        emit_offset = token_start_next;
        emit_length = token_count_len_next;
        emit_cap    = token_cap_next;
      end
      byte_position_next   = '0;
      in_token_next        = 1'b0;
      token_start_next     = '0;
      token_count_len_next = '0;
      sentence_start_next  = 1'b1;
      token_cap_next       = 1'b0;
      scan_stopped_next    = 1'b0;
    end else if (byte_position < POS_MAX) begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      in_token        <= 1'b0;
      token_start     <= '0;
      token_count_len <= '0;
      sentence_start  <= 1'b1;
      token_cap       <= 1'b0;
      scan_stopped    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        byte_position   <= byte_position_next;
        in_token        <= in_token_next;
        token_start     <= token_start_next;
        token_count_len <= token_count_len_next;
        sentence_start  <= sentence_start_next;
        token_cap       <= token_cap_next;
        scan_stopped    <= scan_stopped_next;
      end
      if (pop && emit)    out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      token_offset <= emit_offset;
      token_length <= emit_length;
      capitalize   <= emit_cap;
    end
  end

endmodule

/* hdl/tag_token_scanner_unit.sv */
// Top level of the tag token scanner: front end, queue and back end.
// A byte accepted into the queue is scanned when the back end pops it, and any
// token result it closes is registered in the output register at that pop.
// Throughput: one byte per cycle, set by the scan state update
// in the back end; a held output stalls the back end and then the queue.
// Reset clears the scan state, the queue, the output and the tag set.
module tag_token_scanner_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_string,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tts_pkg::OFF_W-1:0]     token_offset,
  output logic [tts_pkg::LEN_W-1:0]     token_length,
  output logic                          capitalize
);
  import tts_pkg::*;

  // Classified items flow from the front end through a two-entry queue,
  // so the input side can still take up to two items while a result waits to be taken.
  queue_status_t q_status;
  byte_class_t   push_data;
  byte_class_t   head;
  logic          push;
  logic          pop;

  tts_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .q_status      (q_status),
    .push          (push),
    .push_data     (push_data)
  );

  tts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // The back end holds all token state and the output register; it takes
  // the queue head only when the output register is free or being drained.
  tts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_offset (token_offset),
    .token_length (token_length),
    .capitalize   (capitalize)
  );

  // No result is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Every presented token has a legal length.
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_length >= LEN_EMIT) && (token_length <= LEN_MAX))
    else $error("token length out of range");

  // The back end never consumes an item while a result is blocked.
  a_no_pop_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop)
    else $error("queue popped while output stalled");

endmodule

/* verif/tb.sv */
// Self-checking testbench of the tag token scanner, with its own scan predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The
  // slowest legal stretch is a drain and settle pause plus a long random
  // stall, which stays far below this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let pass after the last expected token before the tag set is
  // rewritten or the run ends.
  localparam int SETTLE_CYCLES = 8;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LOW_A  = 8'h61;

  // One emitted token as it appears on the output ports.
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             cap;
  } token_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = '0;
  logic                  end_of_string = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OFF_W-1:0]      token_offset;
  logic [LEN_W-1:0]      token_length;
  logic                  capitalize;

  // Predictor copy of the tag set and of the scan state.
  logic [255:0]     tag_bits = '0;
  logic [POS_W-1:0] scan_pos = '0;
  logic             token_open = 1'b0;
  logic [OFF_W-1:0] open_start = '0;
  logic [LEN_W-1:0] open_len = '0;
  logic             no_letter_yet = 1'b1;
  logic             open_cap = 1'b0;
  logic             scan_halted = 1'b0;

  token_t expected_tokens[$];
  token_t arrived_token;

  int send_idle_pct = 18;
  int recv_idle_pct = 56;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  tag_token_scanner_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_offset  (token_offset),
    .token_length  (token_length),
    .capitalize    (capitalize)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Byte classes used by the predictor. Only ASCII letters and digits
  // count; codes 128 to 255 are neither.
  // ---------------------------------------------------------------------
  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  // A zero byte is never a tag, whatever bit 0 of the set says.
  function automatic logic is_tag(input logic [7:0] c);
    return (c != CHAR_NUL) && tag_bits[c];
  endfunction

  // Queue the open token as an expected result if it is long enough.
  // Returns whether a token was queued.
  function automatic logic close_open_token();
    token_t tok;
    if (!token_open || open_len < LEN_EMIT)
      return 1'b0;
    tok.offset = open_start;
    tok.length = open_len;
    tok.cap = open_cap;
    expected_tokens.push_back(tok);
    return 1'b1;
  endfunction

  // Advance the predicted scan state by one accepted byte and queue the
  // token, if any, that this byte closes.
  task automatic scan_byte(input logic [7:0] c, input logic eos);
    logic extended;
    logic emitted;
    extended = 1'b0;
    emitted = 1'b0;
    if (!scan_halted) begin
      if (token_open) begin
        if (is_alnum(c)) begin
          // Any letter or digit extends the token, tag bytes included.
          if (open_len < LEN_MAX)
            open_len = open_len + LEN_W'(1);
          extended = 1'b1;
        end else begin
          emitted = close_open_token();
          token_open = 1'b0;
        end
      end
      // The byte that closed a token may open the next one.
      if (!extended && is_tag(c)) begin
        token_open = 1'b1;
        open_start = (scan_pos < POS_W'(OFF_MAX)) ? scan_pos[OFF_W-1:0] : OFF_MAX;
        open_len = LEN_W'(1);
        if (is_letter(c))
          open_cap = 1'b0;
        else if (c == CHAR_PERIOD)
          open_cap = 1'b1;
        else
          open_cap = no_letter_yet;
      end
      if (c == CHAR_NUL)
        scan_halted = 1'b1;
      if (is_letter(c))
        no_letter_yet = 1'b0;
      else if (c == CHAR_PERIOD)
        no_letter_yet = 1'b1;
    end
    if (eos) begin
      // A byte closes at most one token, so the end of the string only
      // emits when the byte itself did not.
      if (!emitted)
        void'(close_open_token());
      scan_pos = '0;
      token_open = 1'b0;
      open_start = '0;
      open_len = '0;
      no_letter_yet = 1'b1;
      open_cap = 1'b0;
      scan_halted = 1'b0;
    end else if (scan_pos < POS_MAX) begin
      scan_pos = scan_pos + POS_W'(1);
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking: every token taken from the output is compared with the
  // oldest expected one. Values are sampled at the edge, before any
  // nonblocking update of that edge lands.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token with no expectation: offset %0d length %0d cap %0d",
                                  token_offset, token_length, capitalize));
      end else begin
        arrived_token = expected_tokens.pop_front();
        if (token_offset !== arrived_token.offset)
          report_mismatch($sformatf("token_offset expected %0d, got %0d",
                                    arrived_token.offset, token_offset));
        if (token_length !== arrived_token.length)
          report_mismatch($sformatf("token_length expected %0d, got %0d",
                                    arrived_token.length, token_length));
        if (capitalize !== arrived_token.cap)
          report_mismatch($sformatf("capitalize expected %0d, got %0d",
                                    arrived_token.cap, capitalize));
      end
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a run that stops moving items is declared hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Present one item, after a random gap, and wait until it is taken. Valid
  // is left high so that a following item can go out with no gap.
  task automatic send_byte(input logic [7:0] c, input logic eos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= c;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    scan_byte(c, eos);
  endtask

  // Send the characters of a string; the last one may end the string.
  task automatic send_text(input string s, input logic close_string);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close_string && (i == s.len() - 1));
  endtask

  // Stop sending and wait until every expected token has come out and the
  // pipeline has had time to drain bytes that produce nothing.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four tag set registers while the block is idle.
  task automatic write_tag_set(input logic [255:0] tags);
    wait_for_quiet();
    cfg_we <= 1'b1;
    cfg_index <= REG_TAG_SET_0;
    cfg_data <= tags[63:0];
    @(posedge clk);
    cfg_index <= REG_TAG_SET_1;
    cfg_data <= tags[127:64];
    @(posedge clk);
    cfg_index <= REG_TAG_SET_2;
    cfg_data <= tags[191:128];
    @(posedge clk);
    cfg_index <= REG_TAG_SET_3;
    cfg_data <= tags[255:192];
    @(posedge clk);
    cfg_we <= 1'b0;
    tag_bits = tags;
  endtask

  // A tag set with a few punctuation tags, a digit and a letter tag, two
  // high codes, and the zero bit set to show that it has no effect.
  function automatic logic [255:0] common_tags();
    logic [255:0] tags;
    tags = '0;
    tags[CHAR_NUL] = 1'b1;
    tags[CH_DOLLAR] = 1'b1;
    tags[CH_PCT] = 1'b1;
    tags[CHAR_PERIOD] = 1'b1;
    tags[CH_FIVE] = 1'b1;
    tags[CH_AT] = 1'b1;
    tags[CH_LOW_A] = 1'b1;
    tags[8'h80] = 1'b1;
    tags[8'hFF] = 1'b1;
    return tags;
  endfunction

  // Try a few random codes for one that is a tag in the current set.
  function automatic logic [7:0] pick_tag_byte();
    logic [7:0] c;
    for (int k = 0; k < 16; k++) begin
      c = 8'($urandom_range(1, 255));
      if (tag_bits[c])
        return c;
    end
    return CH_DOLLAR;
  endfunction

  // One byte of random text, weighted toward the bytes that drive the
  // scan: letters, digits, tags, separators and periods, with some noise.
  function automatic logic [7:0] random_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 28)
      return $urandom_range(1) ? 8'(8'h41 + $urandom_range(25)) : 8'(8'h61 + $urandom_range(25));
    else if (r < 40)
      return 8'(8'h30 + $urandom_range(9));
    else if (r < 58)
      return pick_tag_byte();
    else if (r < 68)
      return CH_SPACE;
    else if (r < 76)
      return CHAR_PERIOD;
    else if (r < 84)
      return 8'($urandom_range(8'h21, 8'h2F));
    else if (r < 92)
      return 8'($urandom_range(128, 255));
    else if (r < 94)
      return CHAR_NUL;
    else
      return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // With an empty tag set no byte starts a token.
  task automatic test_no_tags();
    write_tag_set('0);
    send_text("$ab .x", 1'b1);
  endtask

  // Hand-built strings that walk through each rule of the scan.
  task automatic test_directed_tokens();
    write_tag_set(common_tags());
    // A token that runs to the end of the string, at the sentence start.
    send_text("$Ab9", 1'b1);
    // A letter tag inside a token extends it; a closing tag opens the next
    // token; a period tag forces a capital; a high tag ends the string.
    send_text("x@ab%5.", 1'b0);
    send_byte(8'hFF, 1'b1);
    // A zero byte closes the token and everything up to the end is ignored.
    send_text("$a", 1'b0);
    send_byte(CHAR_NUL, 1'b0);
    send_text("$b", 1'b1);
    // A letter tag opening a token never asks for a capital.
    send_text("ab", 1'b1);
    // High codes are not alphanumeric, so they close a token.
    send_byte(8'h80, 1'b0);
    send_text("Z", 1'b0);
    send_byte(8'hFE, 1'b1);
    // A zero byte that is also the whole string.
    send_byte(CHAR_NUL, 1'b1);
  endtask

  // Random strings of mostly short length, each ended by end_of_string.
  task automatic test_random_text(input int item_target);
    int sent;
    int len;
    sent = 0;
    while (sent < item_target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 30);
      for (int i = 0; i < len; i++)
        send_byte(random_text_byte(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles little, receiver idles much.
    send_idle_pct = 18;
    recv_idle_pct = 56;
    test_no_tags();
    test_directed_tokens();
    test_random_text(230);

    // Roles swapped, with a random tag set.
    send_idle_pct = 56;
    recv_idle_pct = 18;
    write_tag_set({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom});
    test_random_text(230);

    // No idling at all, with every nonzero code a tag.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tag_set('1);
    test_random_text(230);

    wait_for_quiet();
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
